>>> rtl/core/deq_pkg.sv
// deq_pkg: shared types and codes for the deque with pop max
// payload structs, operation kinds, status codes and controller/datapath links
// no dependencies
package deq_pkg;

  localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [2:0] KIND_POP_BACK   = 3'd2;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [2:0] KIND_POP_MAX    = 3'd4;
  localparam logic [2:0] KIND_PEEK_BACK  = 3'd5;
  localparam logic [2:0] KIND_PEEK_FRONT = 3'd6;
  localparam logic [2:0] KIND_NOP        = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } deq_out_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic emit_now;
    logic rd_end;
    logic finish_end;
    logic scan_start;
    logic scan_step;
    logic move_start;
    logic move_step;
    logic finish_max;
  } deq_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_nop;
    logic is_popmax;
    logic full;
    logic empty;
    logic scan_done;
    logic has_next;
    logic move_done;
  } deq_sts_t;

endpackage

>>> rtl/core/deq_datapath.sv
// deq_datapath: entry memory, front pointer, count, max scan and compaction
// driven by deq_ctrl through deq_cmd_t, reports back through deq_sts_t
// depends on deq_pkg
module deq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  deq_pkg::deq_in_t  in_i,
  input  deq_pkg::deq_cmd_t cmd_i,
  output deq_pkg::deq_sts_t sts_o,
  output deq_pkg::deq_out_t result_o
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [31:0]        mem [DEPTH];
  logic signed [31:0] rdata_q;
  logic [2:0]         kind_q;
  logic signed [31:0] value_q;
  logic [AW-1:0]      front_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic [AW-1:0]      best_q;
  logic signed [31:0] best_val_q;
  logic [AW-1:0]      mov_q;
  deq_out_t           res_q;

  logic [CW-1:0] cm1;
  logic [CW-1:0] idx_m1;
  logic [CW:0]   best_p1;
  logic [CW:0]   mov_p2;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic          scan_done;
  logic          move_done;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [AW-1:0] o);
    logic [AW:0] sum;
    sum = {1'b0, f} + {1'b0, o};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    cm1       = count_q - 1'b1;
    idx_m1    = idx_q - 1'b1;
    best_p1   = (CW+1)'(best_q) + (CW+1)'(1);
    mov_p2    = (CW+1)'(mov_q) + (CW+1)'(2);
    front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
    front_inc = slot(front_q, AW'(1));
    scan_done = (idx_q == count_q);
    move_done = (mov_p2 >= {1'b0, count_q});
  end

  always_comb begin
    sts_o.is_push   = (kind_q == KIND_PUSH_BACK) || (kind_q == KIND_PUSH_FRONT);
    sts_o.is_nop    = (kind_q == KIND_NOP);
    sts_o.is_popmax = (kind_q == KIND_POP_MAX);
    sts_o.full      = (count_q == DEPTH_C);
    sts_o.empty     = (count_q == '0);
    sts_o.scan_done = scan_done;
    sts_o.has_next  = (best_p1 < {1'b0, count_q});
    sts_o.move_done = move_done;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = front_q;
    we      = 1'b0;
    waddr   = front_q;
    wdata   = value_q;
    if (cmd_i.push) begin
      we = 1'b1;
      if (kind_q == KIND_PUSH_FRONT) begin
        waddr = front_dec;
      end else begin
        waddr = slot(front_q, count_q[AW-1:0]);
      end
    end
    if (cmd_i.move_step) begin
      we    = 1'b1;
      waddr = slot(front_q, mov_q);
      wdata = rdata_q;
    end
    if (cmd_i.rd_end) begin
      rd_en = 1'b1;
      if (kind_q inside {KIND_POP_BACK, KIND_PEEK_BACK}) begin
        rd_addr = slot(front_q, cm1[AW-1:0]);
      end else begin
        rd_addr = front_q;
      end
    end
    if (cmd_i.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = front_q;
    end
    if (cmd_i.scan_step && !scan_done) begin
      rd_en   = 1'b1;
      rd_addr = slot(front_q, idx_q[AW-1:0]);
    end
    if (cmd_i.move_start) begin
      rd_en   = 1'b1;
      rd_addr = slot(front_q, best_p1[AW-1:0]);
    end
    if (cmd_i.move_step && !move_done) begin
      rd_en   = 1'b1;
      rd_addr = slot(front_q, mov_p2[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.push) begin
        count_q <= count_q + 1'b1;
        if (kind_q == KIND_PUSH_FRONT) begin
          front_q <= front_dec;
        end
      end
      if (cmd_i.finish_end && (kind_q inside {KIND_POP_BACK, KIND_POP_FRONT})) begin
        count_q <= cm1;
        if (kind_q == KIND_POP_FRONT) begin
          front_q <= front_inc;
        end
      end
      if (cmd_i.finish_max) begin
        count_q <= cm1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= in_i.kind;
      value_q <= in_i.value;
    end
    if (cmd_i.scan_start) begin
      idx_q <= CW'(1);
    end
    if (cmd_i.scan_step) begin
      if ((idx_q == CW'(1)) || (rdata_q > best_val_q)) begin
        best_q     <= idx_m1[AW-1:0];
        best_val_q <= rdata_q;
      end
      if (!scan_done) begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (cmd_i.move_start) begin
      mov_q <= best_q;
    end
    if (cmd_i.move_step) begin
      mov_q <= mov_q + 1'b1;
    end
    if (cmd_i.push) begin
      res_q.result_value <= '0;
      res_q.status       <= ST_OK;
      res_q.occupancy    <= 5'(count_q + 1'b1);
    end
    if (cmd_i.emit_now) begin
      res_q.result_value <= '0;
      res_q.occupancy    <= 5'(count_q);
      if (sts_o.is_push) begin
        res_q.status <= ST_FULL;
      end else if (sts_o.is_nop) begin
        res_q.status <= ST_OK;
      end else begin
        res_q.status <= ST_EMPTY;
      end
    end
    if (cmd_i.finish_end) begin
      res_q.result_value <= rdata_q;
      res_q.status       <= ST_OK;
      if (kind_q inside {KIND_POP_BACK, KIND_POP_FRONT}) begin
        res_q.occupancy <= 5'(cm1);
      end else begin
        res_q.occupancy <= 5'(count_q);
      end
    end
    if (cmd_i.finish_max) begin
      res_q.result_value <= best_val_q;
      res_q.status       <= ST_OK;
      res_q.occupancy    <= 5'(cm1);
    end
  end

  assign result_o = res_q;

endmodule

>>> rtl/core/deq_ctrl.sv
// deq_ctrl: operation sequencer for the deque
// issues deq_cmd_t to deq_datapath from its deq_sts_t, drives busy and done
// depends on deq_pkg
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  deq_pkg::deq_sts_t sts_i,
  output deq_pkg::deq_cmd_t cmd_o
);
  import deq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_READ     = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_MSTART   = 3'd4;
  localparam logic [2:0] S_MOVE     = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       done_q;
  logic       done_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        if (sts_i.is_push) begin
          if (sts_i.full) begin
            cmd_o.emit_now = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
          end
        end else if (sts_i.is_nop || sts_i.empty) begin
          cmd_o.emit_now = 1'b1;
        end else if (sts_i.is_popmax) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          cmd_o.rd_end = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        cmd_o.finish_end = 1'b1;
        state_d          = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        if (sts_i.has_next) begin
          cmd_o.move_start = 1'b1;
          state_d          = S_MOVE;
        end else begin
          cmd_o.finish_max = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_MOVE: begin
        cmd_o.move_step = 1'b1;
        if (sts_i.move_done) begin
          cmd_o.finish_max = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_d = cmd_o.push | cmd_o.emit_now | cmd_o.finish_end | cmd_o.finish_max;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

>>> rtl/core/deque_with_extract_max_top.sv
// deque_with_extract_max_top: bounded deque of signed 32-bit values with pop max
// joins deq_ctrl and deq_datapath; depends on deq_pkg
//
// usage:
//   an operation beat is taken at a rising edge with start high and busy low;
//   in_i carries the kind and the value to push
//   every operation gives one result beat: done_o is high for exactly one cycle
//   with result_o holding the popped or peeked value, status and occupancy
//   the receiver cannot stall, so each result beat is taken in its done_o cycle
// steps from the accepting edge; done_o is registered after the last one:
//   push, failed or empty operation, unused kind: dispatch state only
//   pop and peek at either end: dispatch, then read (registered memory read)
//   pop max: dispatch, a scan over the n entries, a move start, then a move
//   of the m entries behind the maximum one place forward, if m is not zero
// one operation is in flight at a time; busy drops as its result beat appears,
// so the next beat can be taken at the edge that ends it
// reset empties the deque and sets the front pointer to slot zero; the entry
// memory itself is not cleared
module deque_with_extract_max_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  deq_pkg::deq_in_t in_i,
  output logic             done_o,
  output deq_pkg::deq_out_t result_o
);
  import deq_pkg::*;

  deq_cmd_t cmd;
  deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule
